// ===== hw/rtl/hvrt_pkg.sv =====
`default_nettype none
package hvrt_pkg;

    // Table geometry.
    localparam int INDEX_SLOTS       = 1024;
    localparam int ROW_CAPACITY      = 512;
    localparam int OVERFLOW_CAPACITY = 64;

    localparam int SLOT_BITS   = $clog2(INDEX_SLOTS);
    localparam int ROW_BITS    = $clog2(ROW_CAPACITY);
    localparam int ROW_CNT_W   = $clog2(ROW_CAPACITY + 1);
    localparam int SPILL_BITS  = $clog2(OVERFLOW_CAPACITY);
    localparam int SPILL_CNT_W = $clog2(OVERFLOW_CAPACITY + 1);

    // Memory word widths.
    localparam int IDX_W   = ROW_BITS + 1;
    localparam int REC_W   = 32 + 64 + 6;
    localparam int SPILL_W = 32 + 64;

    // Hash constants.
    localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
    localparam int          MIX_SHIFT = 33;

    // Operation codes.
    localparam logic [2:0] OP_BEGIN      = 3'd0;
    localparam logic [2:0] OP_OBSERVE    = 3'd1;
    localparam logic [2:0] OP_SUBMITTED  = 3'd2;
    localparam logic [2:0] OP_GPU_CAND   = 3'd3;
    localparam logic [2:0] OP_FRUSTUM    = 3'd4;
    localparam logic [2:0] OP_READ_ROW   = 3'd5;
    localparam logic [2:0] OP_INVALIDATE = 3'd6;

    // Result status codes.
    localparam logic [2:0] STS_IGNORED   = 3'd0;
    localparam logic [2:0] STS_HIT       = 3'd1;
    localparam logic [2:0] STS_CREATED   = 3'd2;
    localparam logic [2:0] STS_ALREADY   = 3'd3;
    localparam logic [2:0] STS_OVF_REC   = 3'd4;
    localparam logic [2:0] STS_INEXACT   = 3'd5;
    localparam logic [2:0] STS_EXHAUSTED = 3'd6;

    // Record state and cause codes.
    localparam logic [2:0] VS_UNAVAIL = 3'd0;
    localparam logic [2:0] VS_OPAQUE  = 3'd1;
    localparam logic [2:0] VS_BLENDED = 3'd2;
    localparam logic [2:0] VS_FRUSTUM = 3'd3;
    localparam logic [2:0] VS_GPU     = 3'd5;

    // What the result row fields are taken from.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_REC  = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       hash_done;
        logic       idx_rd;
        logic       probe_next;
        logic       rec_rd_ptr;
        logic       rec_rd_idx;
        logic       spill_start;
        logic       spill_rd;
        logic       spill_next;
        logic       do_create;
        logic       do_update;
        logic       do_spill_add;
        logic       do_inexact;
        logic       do_begin;
        logic       do_inval;
        logic       clr_start;
        logic       clr_en;
        logic       load_out;
        logic [2:0] out_status;
        logic [1:0] out_kind;
    } hvrt_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       key_ok;
        logic       ridx_ok;
        logic       occ;
        logic       rec_match;
        logic       spill_match;
        logic       rows_full;
        logic       spill_more;
        logic       spill_full;
        logic       probe_last;
        logic       clr_last;
    } hvrt_sts_t;

    // New state and cause of a record for an operation that hit it.
    function automatic logic [5:0] next_sc(logic [2:0] op, logic transp, logic [5:0] sc);
        logic [5:0] r;
        r = sc;
        case (op)
            OP_SUBMITTED: begin
                r = transp ? {VS_BLENDED, VS_BLENDED} : {VS_OPAQUE, VS_OPAQUE};
            end
            OP_GPU_CAND: begin
                if (sc[2:0] == VS_UNAVAIL) r = {VS_GPU, VS_GPU};
            end
            OP_FRUSTUM: begin
                if (sc[2:0] != VS_OPAQUE && sc[2:0] != VS_BLENDED) r = {VS_FRUSTUM, VS_FRUSTUM};
            end
            default: begin
                r = sc;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hvrt_ram.sv =====
`default_nettype none
module hvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hvrt_ctrl.sv =====
`default_nettype none
module hvrt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire hvrt_pkg::hvrt_sts_t sts,
    output hvrt_pkg::hvrt_cmd_t     cmd
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_H0   = 4'd3;
    localparam logic [3:0] S_H1   = 4'd4;
    localparam logic [3:0] S_H2   = 4'd5;
    localparam logic [3:0] S_H3   = 4'd6;
    localparam logic [3:0] S_H4   = 4'd7;
    localparam logic [3:0] S_PRD  = 4'd8;
    localparam logic [3:0] S_PCHK = 4'd9;
    localparam logic [3:0] S_RCHK = 4'd10;
    localparam logic [3:0] S_SPT  = 4'd11;
    localparam logic [3:0] S_SPC  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [2:0] res_status_reg, res_status_next;
    logic [1:0] res_kind_reg, res_kind_next;
    logic       clr_res_reg, clr_res_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Sequencer: one transaction at a time through hash, probe and spill scan.
    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_kind_next   = res_kind_reg;
        clr_res_next    = clr_res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd.out_status  = res_status_reg;
        cmd.out_kind    = res_kind_reg;
        case (state_reg)
            S_CLR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) state_next = clr_res_reg ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                res_status_next = hvrt_pkg::STS_IGNORED;
                res_kind_next   = hvrt_pkg::KIND_NONE;
                state_next      = S_DONE;
                case (sts.op)
                    hvrt_pkg::OP_BEGIN: begin
                        cmd.do_begin  = 1'b1;
                        cmd.clr_start = 1'b1;
                        clr_res_next  = 1'b1;
                        state_next    = S_CLR;
                    end
                    hvrt_pkg::OP_INVALIDATE: begin
                        cmd.do_inval  = 1'b1;
                        cmd.clr_start = 1'b1;
                        clr_res_next  = 1'b1;
                        state_next    = S_CLR;
                    end
                    hvrt_pkg::OP_READ_ROW: begin
                        if (sts.ridx_ok) begin
                            cmd.rec_rd_idx  = 1'b1;
                            res_status_next = hvrt_pkg::STS_HIT;
                            res_kind_next   = hvrt_pkg::KIND_REC;
                        end
                    end
                    hvrt_pkg::OP_OBSERVE, hvrt_pkg::OP_SUBMITTED,
                    hvrt_pkg::OP_GPU_CAND, hvrt_pkg::OP_FRUSTUM: begin
                        if (sts.key_ok) state_next = S_H0;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_H0: begin
                cmd.mul_en = 1'b1; cmd.mul_step = 2'd0; state_next = S_H1;
            end
            S_H1: begin
                cmd.mul_en = 1'b1; cmd.mul_step = 2'd1; state_next = S_H2;
            end
            S_H2: begin
                cmd.mul_en = 1'b1; cmd.mul_step = 2'd2; state_next = S_H3;
            end
            S_H3: begin
                cmd.mul_en = 1'b1; cmd.mul_step = 2'd3; state_next = S_H4;
            end
            S_H4: begin
                cmd.hash_done = 1'b1;
                state_next    = S_PRD;
            end
            S_PRD: begin
                cmd.idx_rd = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK: begin
                if (sts.occ) begin
                    cmd.rec_rd_ptr = 1'b1;
                    state_next     = S_RCHK;
                end else if (sts.op != hvrt_pkg::OP_OBSERVE) begin
                    res_status_next = hvrt_pkg::STS_IGNORED;
                    res_kind_next   = hvrt_pkg::KIND_NONE;
                    state_next      = S_DONE;
                end else if (sts.rows_full) begin
                    cmd.spill_start = 1'b1;
                    state_next      = S_SPT;
                end else begin
                    cmd.do_create   = 1'b1;
                    res_status_next = hvrt_pkg::STS_CREATED;
                    res_kind_next   = hvrt_pkg::KIND_KEY;
                    state_next      = S_DONE;
                end
            end
            S_RCHK: begin
                if (sts.rec_match) begin
                    cmd.do_update   = 1'b1;
                    res_status_next = hvrt_pkg::STS_HIT;
                    res_kind_next   = hvrt_pkg::KIND_REC;
                    state_next      = S_DONE;
                end else if (sts.probe_last) begin
                    res_status_next = hvrt_pkg::STS_EXHAUSTED;
                    res_kind_next   = hvrt_pkg::KIND_KEY;
                    state_next      = S_DONE;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PRD;
                end
            end
            S_SPT: begin
                res_kind_next = hvrt_pkg::KIND_KEY;
                if (sts.spill_more) begin
                    cmd.spill_rd = 1'b1;
                    state_next   = S_SPC;
                end else if (!sts.spill_full) begin
                    cmd.do_spill_add = 1'b1;
                    res_status_next  = hvrt_pkg::STS_OVF_REC;
                    state_next       = S_DONE;
                end else begin
                    cmd.do_inexact  = 1'b1;
                    res_status_next = hvrt_pkg::STS_INEXACT;
                    state_next      = S_DONE;
                end
            end
            S_SPC: begin
                if (sts.spill_match) begin
                    res_status_next = hvrt_pkg::STS_ALREADY;
                    res_kind_next   = hvrt_pkg::KIND_KEY;
                    state_next      = S_DONE;
                end else begin
                    cmd.spill_next = 1'b1;
                    state_next     = S_SPT;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the index clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            res_status_reg <= hvrt_pkg::STS_IGNORED;
            res_kind_reg   <= hvrt_pkg::KIND_NONE;
            clr_res_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_kind_reg   <= res_kind_next;
            clr_res_reg    <= clr_res_next;
            m_valid_reg    <= m_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hvrt_dpath.sv =====
`default_nettype none
module hvrt_dpath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hvrt_pkg::hvrt_cmd_t cmd,
    output hvrt_pkg::hvrt_sts_t      sts,
    input  wire logic [2:0]          s_op,
    input  wire logic [63:0]         s_entity,
    input  wire logic [31:0]         s_world_id,
    input  wire logic                s_world_valid,
    input  wire logic                s_transparent,
    input  wire logic [63:0]         s_frame,
    input  wire logic [15:0]         s_view_slot,
    input  wire logic [8:0]          s_row_index,
    output logic      [2:0]          m_status,
    output logic      [31:0]         m_row_world,
    output logic      [63:0]         m_row_entity,
    output logic      [2:0]          m_row_state,
    output logic      [2:0]          m_row_cause,
    output logic                     m_active,
    output logic      [9:0]          m_row_count,
    output logic      [6:0]          m_dropped_count,
    output logic                     m_dropped_exact,
    output logic      [63:0]         m_frame_out,
    output logic      [15:0]         m_view_slot_out,
    output logic      [31:0]         m_view_world
);
    localparam int SLOT_BITS   = hvrt_pkg::SLOT_BITS;
    localparam int ROW_BITS    = hvrt_pkg::ROW_BITS;
    localparam int ROW_CNT_W   = hvrt_pkg::ROW_CNT_W;
    localparam int SPILL_BITS  = hvrt_pkg::SPILL_BITS;
    localparam int SPILL_CNT_W = hvrt_pkg::SPILL_CNT_W;

    // Table state.
    logic                   active_reg;
    logic [63:0]            cur_frame_reg;
    logic [15:0]            cur_vslot_reg;
    logic [31:0]            cur_vworld_reg;
    logic [ROW_CNT_W-1:0]   rows_reg;
    logic [SPILL_CNT_W-1:0] used_reg;
    logic [6:0]             tally_reg;
    logic                   exact_reg;

    // Captured transaction.
    logic [2:0]          op_reg;
    logic [63:0]         ent_reg;
    logic [31:0]         w_reg;
    logic                transp_reg;
    logic [63:0]         frame_reg;
    logic [15:0]         vslot_reg;
    logic [ROW_BITS-1:0] ridx_reg;

    // Hash, probe and scan registers.
    logic [63:0]            prod_reg;
    logic [63:0]            acc_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   probe_reg;
    logic [SLOT_BITS-1:0]   clr_reg;
    logic [ROW_BITS-1:0]    rec_addr_reg;
    logic [SPILL_CNT_W-1:0] spill_i_reg;

    logic [63:0] key_x;
    logic [31:0] mul_a, mul_b;
    logic [5:0]  sc_new;

    logic [hvrt_pkg::IDX_W-1:0]   idx_rdata, idx_wdata;
    logic [SLOT_BITS-1:0]         idx_waddr;
    logic [hvrt_pkg::REC_W-1:0]   rec_rdata, rec_wdata;
    logic [ROW_BITS-1:0]          rec_raddr, rec_waddr;
    logic [hvrt_pkg::SPILL_W-1:0] spill_rdata;

    // First xor-shift of the key, then the operand pair for each partial product.
    assign key_x = ({w_reg, 32'd0} ^ ent_reg) ^
                   (({w_reg, 32'd0} ^ ent_reg) >> hvrt_pkg::MIX_SHIFT);

    always_comb begin
        case (cmd.mul_step)
            2'd1: begin
                mul_a = key_x[31:0];  mul_b = hvrt_pkg::MIX_MULT[63:32];
            end
            2'd2: begin
                mul_a = key_x[63:32]; mul_b = hvrt_pkg::MIX_MULT[31:0];
            end
            default: begin
                mul_a = key_x[31:0];  mul_b = hvrt_pkg::MIX_MULT[31:0];
            end
        endcase
    end

    assign sc_new = hvrt_pkg::next_sc(op_reg, transp_reg, rec_rdata[5:0]);

    // Status back to the sequencer.
    assign sts.op          = op_reg;
    assign sts.key_ok      = active_reg && (ent_reg != 64'd0);
    assign sts.ridx_ok     = {{(ROW_CNT_W-ROW_BITS){1'b0}}, ridx_reg} < rows_reg;
    assign sts.occ         = idx_rdata[hvrt_pkg::IDX_W-1];
    assign sts.rec_match   = (rec_rdata[101:70] == w_reg) && (rec_rdata[69:6] == ent_reg);
    assign sts.spill_match = (spill_rdata[95:64] == w_reg) && (spill_rdata[63:0] == ent_reg);
    assign sts.rows_full   = rows_reg >= ROW_CNT_W'(hvrt_pkg::ROW_CAPACITY);
    assign sts.spill_more  = spill_i_reg < used_reg;
    assign sts.spill_full  = used_reg >= SPILL_CNT_W'(hvrt_pkg::OVERFLOW_CAPACITY);
    assign sts.probe_last  = probe_reg == SLOT_BITS'(hvrt_pkg::INDEX_SLOTS - 1);
    assign sts.clr_last    = clr_reg == SLOT_BITS'(hvrt_pkg::INDEX_SLOTS - 1);

    // Memory port selection.
    assign idx_waddr = cmd.clr_en ? clr_reg : slot_reg;
    assign idx_wdata = cmd.clr_en ? '0 : {1'b1, rows_reg[ROW_BITS-1:0]};
    assign rec_raddr = cmd.rec_rd_ptr ? idx_rdata[ROW_BITS-1:0] : ridx_reg;
    assign rec_waddr = cmd.do_create ? rows_reg[ROW_BITS-1:0] : rec_addr_reg;
    assign rec_wdata = cmd.do_create ? {w_reg, ent_reg, 6'd0} : {rec_rdata[101:6], sc_new};

    hvrt_ram #(.WIDTH(hvrt_pkg::IDX_W), .DEPTH(hvrt_pkg::INDEX_SLOTS)) u_index (
        .aclk  (aclk),
        .we    (cmd.clr_en || cmd.do_create),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .re    (cmd.idx_rd),
        .raddr (slot_reg),
        .rdata (idx_rdata)
    );

    hvrt_ram #(.WIDTH(hvrt_pkg::REC_W), .DEPTH(hvrt_pkg::ROW_CAPACITY)) u_rows (
        .aclk  (aclk),
        .we    (cmd.do_create || cmd.do_update),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (cmd.rec_rd_ptr || cmd.rec_rd_idx),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    hvrt_ram #(.WIDTH(hvrt_pkg::SPILL_W), .DEPTH(hvrt_pkg::OVERFLOW_CAPACITY)) u_spill (
        .aclk  (aclk),
        .we    (cmd.do_spill_add),
        .waddr (used_reg[SPILL_BITS-1:0]),
        .wdata ({w_reg, ent_reg}),
        .re    (cmd.spill_rd),
        .raddr (spill_i_reg[SPILL_BITS-1:0]),
        .rdata (spill_rdata)
    );

    // Table state: begin, invalidate, row and overflow bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            cur_frame_reg  <= '0;
            cur_vslot_reg  <= '0;
            cur_vworld_reg <= '0;
            rows_reg       <= '0;
            used_reg       <= '0;
            tally_reg      <= '0;
            exact_reg      <= 1'b1;
        end else begin
            if (cmd.do_begin || cmd.do_inval) begin
                active_reg     <= cmd.do_begin;
                cur_frame_reg  <= cmd.do_begin ? frame_reg : 64'd0;
                cur_vslot_reg  <= cmd.do_begin ? vslot_reg : 16'd0;
                cur_vworld_reg <= cmd.do_begin ? w_reg : 32'd0;
                rows_reg       <= '0;
                used_reg       <= '0;
                tally_reg      <= '0;
                exact_reg      <= 1'b1;
            end
            if (cmd.do_create) rows_reg <= rows_reg + 1'b1;
            if (cmd.do_spill_add) begin
                used_reg <= used_reg + 1'b1;
                if (exact_reg) tally_reg <= tally_reg + 1'b1;
            end
            if (cmd.do_inexact) exact_reg <= 1'b0;
        end
    end

    // Clearing sweep counter over the index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_start) begin
            clr_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Transaction capture, hash partial products, probe and scan pointers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_op;
            ent_reg    <= s_entity;
            w_reg      <= (s_op == hvrt_pkg::OP_BEGIN || s_world_valid) ?
                          s_world_id : cur_vworld_reg;
            transp_reg <= s_transparent;
            frame_reg  <= s_frame;
            vslot_reg  <= s_view_slot;
            ridx_reg   <= s_row_index;
        end
        if (cmd.mul_en) begin
            prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
            case (cmd.mul_step)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                2'd3:    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                default: acc_reg <= acc_reg;
            endcase
        end
        if (cmd.hash_done) begin
            slot_reg  <= acc_reg[SLOT_BITS-1:0] ^
                         acc_reg[hvrt_pkg::MIX_SHIFT +: SLOT_BITS];
            probe_reg <= '0;
        end
        if (cmd.probe_next) begin
            slot_reg  <= slot_reg + 1'b1;
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.rec_rd_ptr) rec_addr_reg <= idx_rdata[ROW_BITS-1:0];
        if (cmd.spill_start) spill_i_reg <= '0;
        if (cmd.spill_next) spill_i_reg <= spill_i_reg + 1'b1;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status        <= cmd.out_status;
            m_active        <= active_reg;
            m_row_count     <= rows_reg;
            m_dropped_count <= tally_reg;
            m_dropped_exact <= exact_reg;
            m_frame_out     <= cur_frame_reg;
            m_view_slot_out <= cur_vslot_reg;
            m_view_world    <= cur_vworld_reg;
            case (cmd.out_kind)
                hvrt_pkg::KIND_KEY: begin
                    m_row_world  <= w_reg;
                    m_row_entity <= ent_reg;
                    m_row_state  <= hvrt_pkg::VS_UNAVAIL;
                    m_row_cause  <= hvrt_pkg::VS_UNAVAIL;
                end
                hvrt_pkg::KIND_REC: begin
                    m_row_world  <= rec_rdata[101:70];
                    m_row_entity <= rec_rdata[69:6];
                    m_row_state  <= sc_new[2:0];
                    m_row_cause  <= sc_new[5:3];
                end
                default: begin
                    m_row_world  <= '0;
                    m_row_entity <= '0;
                    m_row_state  <= hvrt_pkg::VS_UNAVAIL;
                    m_row_cause  <= hvrt_pkg::VS_UNAVAIL;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hashed_visibility_record_table.sv =====
`default_nettype none
// Per-frame visibility record table keyed by (world, entity).
// Input channel s_*: one operation per transaction (begin, observe, submitted,
// gpu candidate, frustum culled, read row, invalidate). Result channel m_*:
// exactly one result transaction per input, in order.
// One operation is in flight at a time; s_ready is high only when idle,
// and the next input is taken in the cycle after the previous result is
// loaded. Read row, unused and ignored operations go from decode straight
// to the result. Key operations run decode and the hash (three 32x32
// partial products on one multiplier), then for each index probe an index
// read, an occupancy check, and a row read and compare. Once the row store
// is full, an observe of a new key scans the overflow list entry by entry.
// Begin and invalidate run a sweep that clears the index memory, one slot
// per cycle, before the result appears.
// After reset the same sweep runs with s_ready low.
// The result sits in an output register: when the receiver stalls, the
// result is held and the next input is still taken, but its result waits
// until the held one has been taken.
module hashed_visibility_record_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [63:0] s_entity,
    input  wire logic [31:0] s_world_id,
    input  wire logic        s_world_valid,
    input  wire logic        s_transparent,
    input  wire logic [63:0] s_frame,
    input  wire logic [15:0] s_view_slot,
    input  wire logic [8:0]  s_row_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [2:0]  m_status,
    output logic      [31:0] m_row_world,
    output logic      [63:0] m_row_entity,
    output logic      [2:0]  m_row_state,
    output logic      [2:0]  m_row_cause,
    output logic             m_active,
    output logic      [9:0]  m_row_count,
    output logic      [6:0]  m_dropped_count,
    output logic             m_dropped_exact,
    output logic      [63:0] m_frame_out,
    output logic      [15:0] m_view_slot_out,
    output logic      [31:0] m_view_world
);
    hvrt_pkg::hvrt_cmd_t cmd;
    hvrt_pkg::hvrt_sts_t sts;

    hvrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hvrt_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_entity        (s_entity),
        .s_world_id      (s_world_id),
        .s_world_valid   (s_world_valid),
        .s_transparent   (s_transparent),
        .s_frame         (s_frame),
        .s_view_slot     (s_view_slot),
        .s_row_index     (s_row_index),
        .m_status        (m_status),
        .m_row_world     (m_row_world),
        .m_row_entity    (m_row_entity),
        .m_row_state     (m_row_state),
        .m_row_cause     (m_row_cause),
        .m_active        (m_active),
        .m_row_count     (m_row_count),
        .m_dropped_count (m_dropped_count),
        .m_dropped_exact (m_dropped_exact),
        .m_frame_out     (m_frame_out),
        .m_view_slot_out (m_view_slot_out),
        .m_view_world    (m_view_world)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/hvrt_checker.sv =====
`default_nettype none
module hvrt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic [2:0] m_row_state,
    input wire logic [2:0] m_row_cause,
    input wire logic       m_active,
    input wire logic [9:0] m_row_count
);
    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped while stalled");

    // Reset starts the index sweep, so no input is taken right after it.
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready) else $error("input ready during clearing sweep");

    // One operation at a time: an accepted transaction closes the input side.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second input taken while busy");

    // A newly created record has no state or cause yet.
    a_created_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == hvrt_pkg::STS_CREATED |->
            m_row_state == hvrt_pkg::VS_UNAVAIL && m_row_cause == hvrt_pkg::VS_UNAVAIL)
        else $error("created record carries state");

    // An inactive table holds no rows.
    a_inactive_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_active |-> m_row_count == 10'd0) else $error("rows in inactive table");
endmodule

bind hashed_visibility_record_table hvrt_checker u_hvrt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_row_state (m_row_state),
    .m_row_cause (m_row_cause),
    .m_active    (m_active),
    .m_row_count (m_row_count)
);
`default_nettype wire

// ===== tb/sv/hvrt_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Watches both channels of the record table, predicts each result and compares.
module hvrt_tb_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [63:0] s_entity,
    input  wire logic [31:0] s_world_id,
    input  wire logic        s_world_valid,
    input  wire logic        s_transparent,
    input  wire logic [63:0] s_frame,
    input  wire logic [15:0] s_view_slot,
    input  wire logic [8:0]  s_row_index,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_status,
    input  wire logic [31:0] m_row_world,
    input  wire logic [63:0] m_row_entity,
    input  wire logic [2:0]  m_row_state,
    input  wire logic [2:0]  m_row_cause,
    input  wire logic        m_active,
    input  wire logic [9:0]  m_row_count,
    input  wire logic [6:0]  m_dropped_count,
    input  wire logic        m_dropped_exact,
    input  wire logic [63:0] m_frame_out,
    input  wire logic [15:0] m_view_slot_out,
    input  wire logic [31:0] m_view_world,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] row_world;
        logic [63:0] row_entity;
        logic [2:0]  row_state;
        logic [2:0]  row_cause;
        logic        active;
        logic [9:0]  row_count;
        logic [6:0]  dropped_count;
        logic        dropped_exact;
        logic [63:0] frame_out;
        logic [15:0] view_slot_out;
        logic [31:0] view_world;
    } table_result_t;

    // Shadow copy of the table.
    logic        tbl_active;
    logic [63:0] tbl_frame;
    logic [15:0] tbl_view_slot;
    logic [31:0] tbl_view_world;
    int          rows_used;
    int          spill_used;
    int          drop_tally;
    logic        drop_exact;
    logic        slot_occ   [hvrt_pkg::INDEX_SLOTS];
    logic [8:0]  slot_ptr   [hvrt_pkg::INDEX_SLOTS];
    logic [31:0] rec_world  [hvrt_pkg::ROW_CAPACITY];
    logic [63:0] rec_entity [hvrt_pkg::ROW_CAPACITY];
    logic [5:0]  rec_sc     [hvrt_pkg::ROW_CAPACITY];
    logic [31:0] spill_world[hvrt_pkg::OVERFLOW_CAPACITY];
    logic [63:0] spill_ent  [hvrt_pkg::OVERFLOW_CAPACITY];

    table_result_t expected_results[$];

    function automatic logic [9:0] hash_slot(logic [31:0] w, logic [63:0] e);
        logic [63:0] k;
        k = {w, 32'd0} ^ e;
        k = k ^ (k >> hvrt_pkg::MIX_SHIFT);
        k = k * hvrt_pkg::MIX_MULT;
        k = k ^ (k >> hvrt_pkg::MIX_SHIFT);
        return k[9:0];
    endfunction

    function automatic void clear_shadow();
        rows_used  = 0;
        spill_used = 0;
        drop_tally = 0;
        drop_exact = 1'b1;
        for (int j = 0; j < hvrt_pkg::INDEX_SLOTS; j++) slot_occ[j] = 1'b0;
    endfunction

    // Linear probe for a key; creates a row or spills it when asked to.
    function automatic logic [2:0] find_key(logic [31:0] w, logic [63:0] e, logic create,
                                            output logic [8:0] row);
        logic [9:0] s;
        logic [8:0] r;
        s = hash_slot(w, e);
        row = '0;
        for (int p = 0; p < hvrt_pkg::INDEX_SLOTS; p++) begin
            if (!slot_occ[s]) begin
                if (!create) return hvrt_pkg::STS_IGNORED;
                if (rows_used >= hvrt_pkg::ROW_CAPACITY) begin
                    for (int i = 0; i < spill_used; i++)
                        if (spill_world[i] == w && spill_ent[i] == e)
                            return hvrt_pkg::STS_ALREADY;
                    if (spill_used < hvrt_pkg::OVERFLOW_CAPACITY) begin
                        spill_world[spill_used] = w;
                        spill_ent[spill_used]   = e;
                        spill_used++;
                        if (drop_exact) drop_tally++;
                        return hvrt_pkg::STS_OVF_REC;
                    end
                    drop_exact = 1'b0;
                    return hvrt_pkg::STS_INEXACT;
                end
                rec_world[rows_used]  = w;
                rec_entity[rows_used] = e;
                rec_sc[rows_used]     = '0;
                slot_ptr[s] = rows_used[8:0];
                slot_occ[s] = 1'b1;
                row = rows_used[8:0];
                rows_used++;
                return hvrt_pkg::STS_CREATED;
            end
            r = slot_ptr[s];
            if (rec_world[r] == w && rec_entity[r] == e) begin
                row = r;
                return hvrt_pkg::STS_HIT;
            end
            s = s + 10'd1;
        end
        return hvrt_pkg::STS_EXHAUSTED;
    endfunction

    function automatic table_result_t predict_result();
        table_result_t res;
        logic [8:0]  row;
        logic        have_row;
        logic [31:0] w;
        logic [5:0]  sc;
        res = '0;
        have_row = 1'b0;
        row = '0;
        if (s_op == hvrt_pkg::OP_BEGIN) begin
            tbl_frame      = s_frame;
            tbl_view_slot  = s_view_slot;
            tbl_view_world = s_world_id;
            tbl_active     = 1'b1;
            clear_shadow();
        end else if (s_op == hvrt_pkg::OP_INVALIDATE) begin
            tbl_active     = 1'b0;
            clear_shadow();
            tbl_frame      = '0;
            tbl_view_slot  = '0;
            tbl_view_world = '0;
        end else if (s_op == hvrt_pkg::OP_READ_ROW) begin
            if (s_row_index < rows_used) begin
                res.status = hvrt_pkg::STS_HIT;
                row = s_row_index;
                have_row = 1'b1;
            end
        end else if (s_op >= hvrt_pkg::OP_OBSERVE && s_op <= hvrt_pkg::OP_FRUSTUM &&
                     tbl_active && s_entity != 0) begin
            w = s_world_valid ? s_world_id : tbl_view_world;
            res.status = find_key(w, s_entity, s_op == hvrt_pkg::OP_OBSERVE, row);
            if (res.status == hvrt_pkg::STS_HIT || res.status == hvrt_pkg::STS_CREATED) begin
                have_row = 1'b1;
                sc = rec_sc[row];
                // Priority rules for the state update.
                if (s_op == hvrt_pkg::OP_SUBMITTED)
                    rec_sc[row] = s_transparent ? {hvrt_pkg::VS_BLENDED, hvrt_pkg::VS_BLENDED}
                                                : {hvrt_pkg::VS_OPAQUE, hvrt_pkg::VS_OPAQUE};
                else if (s_op == hvrt_pkg::OP_GPU_CAND && sc[2:0] == hvrt_pkg::VS_UNAVAIL)
                    rec_sc[row] = {hvrt_pkg::VS_GPU, hvrt_pkg::VS_GPU};
                else if (s_op == hvrt_pkg::OP_FRUSTUM && sc[2:0] != hvrt_pkg::VS_OPAQUE &&
                         sc[2:0] != hvrt_pkg::VS_BLENDED)
                    rec_sc[row] = {hvrt_pkg::VS_FRUSTUM, hvrt_pkg::VS_FRUSTUM};
            end else if (res.status != hvrt_pkg::STS_IGNORED) begin
                res.row_world  = w;
                res.row_entity = s_entity;
            end
        end
        if (have_row) begin
            res.row_world  = rec_world[row];
            res.row_entity = rec_entity[row];
            res.row_state  = rec_sc[row][2:0];
            res.row_cause  = rec_sc[row][5:3];
        end
        res.active        = tbl_active;
        res.row_count     = rows_used[9:0];
        res.dropped_count = drop_tally[6:0];
        res.dropped_exact = drop_exact;
        res.frame_out     = tbl_frame;
        res.view_slot_out = tbl_view_slot;
        res.view_world    = tbl_view_world;
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Predict on each accepted input transaction, compare on each result transaction.
    always @(posedge aclk) begin
        table_result_t exp_r;
        if (!aresetn) begin
            tbl_active     = 1'b0;
            tbl_frame      = '0;
            tbl_view_slot  = '0;
            tbl_view_world = '0;
            clear_shadow();
            expected_results.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(predict_result());
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expected result waiting");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("status", 64'(exp_r.status), 64'(m_status));
                    check_field("row_world", 64'(exp_r.row_world), 64'(m_row_world));
                    check_field("row_entity", exp_r.row_entity, m_row_entity);
                    check_field("row_state", 64'(exp_r.row_state), 64'(m_row_state));
                    check_field("row_cause", 64'(exp_r.row_cause), 64'(m_row_cause));
                    check_field("active", 64'(exp_r.active), 64'(m_active));
                    check_field("row_count", 64'(exp_r.row_count), 64'(m_row_count));
                    check_field("dropped_count", 64'(exp_r.dropped_count),
                                64'(m_dropped_count));
                    check_field("dropped_exact", 64'(exp_r.dropped_exact),
                                64'(m_dropped_exact));
                    check_field("frame_out", exp_r.frame_out, m_frame_out);
                    check_field("view_slot_out", 64'(exp_r.view_slot_out),
                                64'(m_view_slot_out));
                    check_field("view_world", 64'(exp_r.view_world), 64'(m_view_world));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int CYCLE_LIMIT = 5000000;

    // Operation code that the block does not define.
    localparam logic [2:0] OP_SPARE = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [63:0] s_entity = '0;
    logic [31:0] s_world_id = '0;
    logic        s_world_valid = 1'b0;
    logic        s_transparent = 1'b0;
    logic [63:0] s_frame = '0;
    logic [15:0] s_view_slot = '0;
    logic [8:0]  s_row_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_row_world;
    logic [63:0] m_row_entity;
    logic [2:0]  m_row_state;
    logic [2:0]  m_row_cause;
    logic        m_active;
    logic [9:0]  m_row_count;
    logic [6:0]  m_dropped_count;
    logic        m_dropped_exact;
    logic [63:0] m_frame_out;
    logic [15:0] m_view_slot_out;
    logic [31:0] m_view_world;

    int errors;
    int pending;
    int sent_count = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    logic [63:0] ent_pool [12];
    logic [31:0] world_pool [3];

    hashed_visibility_record_table dut (.*);

    hvrt_tb_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run-length guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Receiver: random wait per result, plus one long hold-off to back up the block.
    int rx_wait = 0;
    int hold_cycles = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && sent_count == 30) begin
            hold_done   <= 1'b1;
            hold_cycles <= 400;
            m_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= (hold_cycles == 1);
        end else if (m_ready && m_valid) begin
            rx_wait = no_idle ? 0 : $urandom_range(0, 15);
            m_ready <= (rx_wait == 0);
        end else if (!m_ready) begin
            if (rx_wait <= 1) begin
                m_ready <= 1'b1;
                rx_wait = 0;
            end else begin
                rx_wait--;
            end
        end
    end

    task automatic send_op(logic [2:0] op, logic [63:0] ent, logic [31:0] wid, logic wv,
                           logic tr, logic [63:0] frm, logic [15:0] vs, logic [8:0] ridx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_entity      <= ent;
        s_world_id    <= wid;
        s_world_valid <= wv;
        s_transparent <= tr;
        s_frame       <= frm;
        s_view_slot   <= vs;
        s_row_index   <= ridx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic key_op(logic [2:0] op, logic [63:0] ent, logic [31:0] wid, logic wv);
        send_op(op, ent, wid, wv, rand_bit(), rand64(), 16'($urandom), 9'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int pick;
        logic [63:0] e;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unused op, inactive table, begin with extreme fields.
        send_op(OP_SPARE, '1, '1, 1'b1, 1'b1, '1, '1, '1);
        key_op(hvrt_pkg::OP_OBSERVE, 64'h1234, 32'h5, 1'b1);
        send_op(hvrt_pkg::OP_BEGIN, '0, '1, 1'b0, 1'b0, '1, '1, '0);
        key_op(hvrt_pkg::OP_OBSERVE, '0, 32'h5, 1'b1);
        key_op(hvrt_pkg::OP_OBSERVE, '1, '1, 1'b1);
        key_op(hvrt_pkg::OP_OBSERVE, 64'h1, 32'h0, 1'b0);
        key_op(hvrt_pkg::OP_OBSERVE, '1, '1, 1'b1);
        send_op(hvrt_pkg::OP_GPU_CAND, '1, '1, 1'b1, 1'b0, '0, '0, '0);
        send_op(hvrt_pkg::OP_SUBMITTED, '1, '1, 1'b1, 1'b1, '0, '0, '0);
        send_op(hvrt_pkg::OP_FRUSTUM, '1, '1, 1'b1, 1'b0, '0, '0, '0);
        send_op(hvrt_pkg::OP_FRUSTUM, 64'h1, '1, 1'b0, 1'b0, '0, '0, '0);
        send_op(hvrt_pkg::OP_SUBMITTED, 64'h1, '1, 1'b0, 1'b0, '0, '0, '0);
        send_op(hvrt_pkg::OP_GPU_CAND, 64'h1, '1, 1'b0, 1'b0, '0, '0, '0);
        key_op(hvrt_pkg::OP_SUBMITTED, 64'h777, 32'h9, 1'b1);
        send_op(hvrt_pkg::OP_READ_ROW, '0, '0, 1'b0, 1'b0, '0, '0, 9'd0);
        send_op(hvrt_pkg::OP_READ_ROW, '0, '0, 1'b0, 1'b0, '0, '0, 9'd1);
        send_op(hvrt_pkg::OP_READ_ROW, '0, '0, 1'b0, 1'b0, '0, '0, 9'd2);
        send_op(hvrt_pkg::OP_READ_ROW, '0, '0, 1'b0, 1'b0, '0, '0, '1);
        send_op(hvrt_pkg::OP_INVALIDATE, '0, '0, 1'b0, 1'b0, '0, '0, '0);
        key_op(hvrt_pkg::OP_OBSERVE, 64'h1, 32'h0, 1'b0);

        // Fill the row store, then spill past the overflow list.
        send_op(hvrt_pkg::OP_BEGIN, '0, $urandom, 1'b1, 1'b0, rand64(), 16'($urandom), '0);
        for (int i = 0; i < hvrt_pkg::ROW_CAPACITY + hvrt_pkg::OVERFLOW_CAPACITY + 2; i++) begin
            no_idle = ((i / 100) % 2) == 1;
            e = rand64() | 64'h1;
            if (i == 100) ent_pool[0] = e;
            if (i == hvrt_pkg::ROW_CAPACITY + 3) ent_pool[1] = e;
            key_op(hvrt_pkg::OP_OBSERVE, e, 32'h1, 1'b1);
        end
        no_idle = 1'b0;
        key_op(hvrt_pkg::OP_OBSERVE, ent_pool[1], 32'h1, 1'b1);
        key_op(hvrt_pkg::OP_OBSERVE, ent_pool[0], 32'h1, 1'b1);
        key_op(hvrt_pkg::OP_SUBMITTED, ent_pool[1], 32'h1, 1'b1);
        send_op(hvrt_pkg::OP_READ_ROW, '0, '0, 1'b0, 1'b0, '0, '0, '1);

        // Sender pauses until every result has arrived.
        wait_drained();

        // Random phases over a small key pool so that hits and updates occur.
        for (int ph = 0; ph < 2; ph++) begin
            no_idle = (ph == 1);
            for (int j = 0; j < 12; j++) ent_pool[j] = rand64();
            for (int j = 0; j < 3; j++) world_pool[j] = $urandom;
            send_op(hvrt_pkg::OP_BEGIN, rand64(), world_pool[0], rand_bit(),
                    rand_bit(), rand64(), 16'($urandom), 9'($urandom));
            for (int n = 0; n < 20; n++) begin
                pick = $urandom_range(0, 99);
                e = ent_pool[$urandom_range(0, 11)];
                if (pick < 35)
                    key_op(hvrt_pkg::OP_OBSERVE, e, world_pool[$urandom_range(0, 2)],
                           rand_bit());
                else if (pick < 50)
                    key_op(hvrt_pkg::OP_SUBMITTED, e, world_pool[$urandom_range(0, 2)],
                           rand_bit());
                else if (pick < 62)
                    key_op(hvrt_pkg::OP_GPU_CAND, e, world_pool[$urandom_range(0, 2)],
                           rand_bit());
                else if (pick < 74)
                    key_op(hvrt_pkg::OP_FRUSTUM, e, world_pool[$urandom_range(0, 2)],
                           rand_bit());
                else if (pick < 88)
                    send_op(hvrt_pkg::OP_READ_ROW, rand64(), $urandom, rand_bit(),
                            rand_bit(), rand64(), 16'($urandom),
                            9'((pick < 84) ? $urandom_range(0, 12) : $urandom_range(0, 511)));
                else if (pick < 93)
                    key_op(3'($urandom_range(1, 4)), '0, $urandom, rand_bit());
                else if (pick < 96)
                    key_op(OP_SPARE, rand64(), $urandom, rand_bit());
                else if (pick < 98)
                    send_op(hvrt_pkg::OP_INVALIDATE, rand64(), $urandom, 1'b1, 1'b1, rand64(),
                            16'($urandom), 9'($urandom));
                else
                    send_op(hvrt_pkg::OP_BEGIN, rand64(), world_pool[1], 1'b0, 1'b0, rand64(),
                            16'($urandom), 9'($urandom));
            end
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
